### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg
// Types and constants shared by the sensor frame checker modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfc_pkg;

    localparam int          SUM_LEN      = 11;     // bytes covered by the checksum
    localparam int          IDX_W        = 4;      // byte index width
    localparam logic [7:0]  MARKER_RESET = 8'h55;
    localparam int          RAW_W        = 16;
    localparam int          SCALE_W      = 12;
    localparam int          PROD_W       = RAW_W + SCALE_W;
    localparam int          ANGLE_W      = 18;
    localparam int          DIV_W        = 10;
    localparam logic [SCALE_W-1:0] ANGLE_SCALE = 12'd3600;
    localparam logic [DIV_W-1:0]   ANGLE_DIV   = 10'd1023;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_START = 2'd1,
        ST_SUM_ERR   = 2'd2
    } t_status;

    // One classified frame, queued between front and back
    typedef struct packed {
        t_status            status;
        logic [RAW_W-1:0]   raw_angle;
        logic [31:0]        position;
        logic [31:0]        timestamp;
    } t_frame;

endpackage

### rtl/core/sfc_front.sv
// ----------------------------------------------------------------------------
// sfc_front
// Byte intake: tracks the byte index, captures frame bytes, keeps the
// running sum and classifies each completed frame into a queue entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_first_byte,
    input  logic [7:0]          i_start_marker,
    input  logic                i_queue_full,
    output logic                o_push,
    output sfc_pkg::t_frame     o_frame
);

    logic [sfc_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic [7:0]                 r_sum, n_sum;
    logic [7:0]                 r_frame [sfc_pkg::SUM_LEN];
    logic [sfc_pkg::IDX_W-1:0]  eff_idx;
    logic                       accept;
    logic                       is_check;

    // Byte transfer is taken whenever the queue has room
    assign o_in_ready = !i_queue_full;
    assign accept     = i_in_valid && o_in_ready;
    assign eff_idx    = i_first_byte ? '0 : r_idx;
    assign is_check   = eff_idx >= sfc_pkg::IDX_W'(sfc_pkg::SUM_LEN);
    assign o_push     = accept && is_check;

    // Index and running sum
    always_comb begin
        n_idx = r_idx;
        n_sum = r_sum;
        if (accept) begin
            if (is_check) begin
                n_idx = '0;
            end else begin
                n_idx = eff_idx + 1'b1;
                n_sum = (eff_idx == '0) ? i_rx_byte : r_sum + i_rx_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_sum <= '0;
        end else begin
            r_idx <= n_idx;
            r_sum <= n_sum;
        end
    end

    // Frame byte capture
    always_ff @(posedge i_clk) begin
        if (accept && !is_check) begin
            r_frame[eff_idx] <= i_rx_byte;
        end
    end

    // Classification of the completed frame
    always_comb begin
        o_frame.raw_angle = {r_frame[2], r_frame[1]};
        o_frame.position  = {r_frame[6], r_frame[5], r_frame[4], r_frame[3]};
        o_frame.timestamp = {r_frame[10], r_frame[9], r_frame[8], r_frame[7]};
        if (r_frame[0] != i_start_marker) begin
            o_frame.status = sfc_pkg::ST_BAD_START;
        end else if (r_sum != i_rx_byte) begin
            o_frame.status = sfc_pkg::ST_SUM_ERR;
        end else begin
            o_frame.status = sfc_pkg::ST_OK;
        end
    end

endmodule

### rtl/core/sfc_queue.sv
// ----------------------------------------------------------------------------
// sfc_queue
// Small FIFO of classified frames between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sfc_queue #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sfc_pkg::t_frame     i_data,
    input  logic                i_pop,
    output sfc_pkg::t_frame     o_data,
    output logic                o_full,
    output logic                o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfc_pkg::t_frame    r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // A push into a full queue would drop a frame result
    `ASSERT_IMP(a_no_push_full, o_full, !i_push, "frame pushed into full queue")
    // Fill count rises by one on a push without a pop
    `ASSERT_NEXT(a_count_step, do_push && !do_pop, r_count == $past(r_count) + 1'b1, "queue count did not advance on push")

endmodule

### rtl/core/sfc_back.sv
// ----------------------------------------------------------------------------
// sfc_back
// Frame execution: angle scaling pipeline (multiply, reciprocal estimate,
// correction), held good values, wrapping counters and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sfc_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_queue_empty,
    input  sfc_pkg::t_frame             i_frame,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_status,
    output logic [sfc_pkg::ANGLE_W-1:0] o_angle_tenths,
    output logic signed [31:0]          o_position,
    output logic [31:0]                 o_timestamp,
    output logic [31:0]                 o_frame_count,
    output logic [31:0]                 o_bad_start_count,
    output logic [31:0]                 o_checksum_error_count
);

    localparam int PW = sfc_pkg::PROD_W;
    localparam int AW = sfc_pkg::ANGLE_W;
    localparam logic [PW:0] REM_LIMIT = (PW + 1)'(2 * sfc_pkg::ANGLE_DIV);

    // Stage 1: product
    logic               r_s1_v;
    logic [PW-1:0]      r_s1_prod;
    sfc_pkg::t_status   r_s1_status;
    logic [31:0]        r_s1_pos;
    logic [31:0]        r_s1_ts;
    // Stage 2: quotient estimate
    logic               r_s2_v;
    logic [PW-1:0]      r_s2_prod;
    logic [AW-1:0]      r_s2_q0;
    sfc_pkg::t_status   r_s2_status;
    logic [31:0]        r_s2_pos;
    logic [31:0]        r_s2_ts;
    // Result register, held values, counters
    logic               r_out_valid;
    sfc_pkg::t_status   r_status;
    logic [AW-1:0]      r_good_angle;
    logic [31:0]        r_good_pos;
    logic [31:0]        r_good_ts;
    logic [31:0]        r_frames;
    logic [31:0]        r_bad_starts;
    logic [31:0]        r_sum_errors;

    logic               out_adv;
    logic               s2_ready;
    logic               s1_adv;
    logic               s1_ready;
    logic [PW:0]        est_sum;
    logic [PW:0]        rem;
    logic [AW-1:0]      q_final;

    // Stall chain, back to front
    assign out_adv  = r_s2_v && (!r_out_valid || i_out_ready);
    assign s2_ready = !r_s2_v || out_adv;
    assign s1_adv   = r_s1_v && s2_ready;
    assign s1_ready = !r_s1_v || s1_adv;
    assign o_pop    = !i_queue_empty && s1_ready;

    // p/1023 estimate: (p + p/1024 + p/2^20) / 1024, low by at most one
    assign est_sum = (PW + 1)'(r_s1_prod) + (PW + 1)'(r_s1_prod >> 10)
                   + (PW + 1)'(r_s1_prod >> 20);

    // Remainder p - 1023*q0 lies in [0, 2045]; one step corrects it
    assign rem     = (PW + 1)'(r_s2_prod) - ((PW + 1)'(r_s2_q0) << sfc_pkg::DIV_W)
                   + (PW + 1)'(r_s2_q0);
    assign q_final = (rem >= (PW + 1)'(sfc_pkg::ANGLE_DIV)) ? r_s2_q0 + 1'b1 : r_s2_q0;

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_v <= 1'b1;
            end else if (out_adv) begin
                r_s2_v <= 1'b0;
            end
            if (out_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_prod   <= PW'(i_frame.raw_angle) * PW'(sfc_pkg::ANGLE_SCALE);
            r_s1_status <= i_frame.status;
            r_s1_pos    <= i_frame.position;
            r_s1_ts     <= i_frame.timestamp;
        end
        if (s1_adv) begin
            r_s2_prod   <= r_s1_prod;
            r_s2_q0     <= AW'(est_sum >> sfc_pkg::DIV_W);
            r_s2_status <= r_s1_status;
            r_s2_pos    <= r_s1_pos;
            r_s2_ts     <= r_s1_ts;
        end
        if (out_adv) begin
            r_status <= r_s2_status;
        end
    end

    // Held good values and counters, updated as each result is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_good_angle <= '0;
            r_good_pos   <= '0;
            r_good_ts    <= '0;
            r_frames     <= '0;
            r_bad_starts <= '0;
            r_sum_errors <= '0;
        end else if (out_adv) begin
            r_frames <= r_frames + 1'b1;
            case (r_s2_status)
                sfc_pkg::ST_BAD_START: r_bad_starts <= r_bad_starts + 1'b1;
                sfc_pkg::ST_SUM_ERR:   r_sum_errors <= r_sum_errors + 1'b1;
                sfc_pkg::ST_OK: begin
                    r_good_angle <= q_final;
                    r_good_pos   <= r_s2_pos;
                    r_good_ts    <= r_s2_ts;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_status               = r_status;
    assign o_angle_tenths         = r_good_angle;
    assign o_position             = r_good_pos;
    assign o_timestamp            = r_good_ts;
    assign o_frame_count          = r_frames;
    assign o_bad_start_count      = r_bad_starts;
    assign o_checksum_error_count = r_sum_errors;

    // Reciprocal estimate must land within one of the true quotient
    `ASSERT_IMP(a_rem_range, r_s2_v, rem < REM_LIMIT, "angle quotient estimate out of range")
    // Every loaded result counts exactly one frame
    `ASSERT_NEXT(a_frame_count, out_adv, r_frames == $past(r_frames) + 1'b1, "frame count skipped")

endmodule

### rtl/core/sensor_frame_checker_top.sv
// Path: checksum byte transfer, queue entry, stage 1, stage 2, result register.
// Throughput: one byte per cycle while the frame queue has room; one result
// per 12-byte frame, set by the byte intake.
// Output stalls back up through the 3-stage angle pipeline into the frame queue.
// Reset (synchronous, active low): index, sum, held values and counters clear,
// start marker returns to 0x55, queue and pipeline empty.
// ----------------------------------------------------------------------------
// sensor_frame_checker_top
// Checks fixed 12-byte sensor frames and reports status, scaled angle,
// position, timestamp and frame counters for each completed frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sensor_frame_checker_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Byte channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [7:0]                  i_rx_byte,
    input  logic                        i_first_byte,
    // Configuration channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [7:0]                  i_start_marker,
    // Result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_status,
    output logic [sfc_pkg::ANGLE_W-1:0] o_angle_tenths,
    output logic signed [31:0]          o_position,
    output logic [31:0]                 o_timestamp,
    output logic [31:0]                 o_frame_count,
    output logic [31:0]                 o_bad_start_count,
    output logic [31:0]                 o_checksum_error_count
);

    logic [7:0]         r_start_marker;
    logic               push;
    logic               pop;
    logic               q_full;
    logic               q_empty;
    sfc_pkg::t_frame    front_frame;
    sfc_pkg::t_frame    head_frame;

    // Start marker register, written on each config transfer
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= sfc_pkg::MARKER_RESET;
        end else if (i_cfg_valid) begin
            r_start_marker <= i_start_marker;
        end
    end

    sfc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .i_first_byte   (i_first_byte),
        .i_start_marker (r_start_marker),
        .i_queue_full   (q_full),
        .o_push         (push),
        .o_frame        (front_frame)
    );

    sfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_frame),
        .i_pop   (pop),
        .o_data  (head_frame),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    sfc_back u_back (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_queue_empty          (q_empty),
        .i_frame                (head_frame),
        .o_pop                  (pop),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .o_status               (o_status),
        .o_angle_tenths         (o_angle_tenths),
        .o_position             (o_position),
        .o_timestamp            (o_timestamp),
        .o_frame_count          (o_frame_count),
        .o_bad_start_count      (o_bad_start_count),
        .o_checksum_error_count (o_checksum_error_count)
    );

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Block-level test of sensor_frame_checker_top. Bytes of 12-byte frames are
// fed through a bursty byte channel while the result channel stalls on its
// own pattern. A frame model in this file predicts status, held values and
// counters for every completed frame, and each result transfer is checked
// field by field against the oldest prediction. The start marker is
// rewritten between phases, only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int FRAME_BYTES      = sfc_pkg::SUM_LEN + 1;
    localparam int ANGLE_MUL        = 3600;
    localparam int ANGLE_DIVISOR    = 1023;
    localparam int SETTLE_CYCLES    = 8;     // idle margin after the last result is checked
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int LONG_HOLD_CYCLES = 250;
    localparam int FRAMES_PER_PHASE = 14;
    localparam int PHASE_COUNT      = 4;
    localparam int HOLD_PHASE       = 2;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
    } t_rx_item;

    typedef struct packed {
        sfc_pkg::t_status            status;
        logic [sfc_pkg::ANGLE_W-1:0] angle;
        logic [31:0]                 position;
        logic [31:0]                 timestamp;
        logic [31:0]                 frame_count;
        logic [31:0]                 bad_start_count;
        logic [31:0]                 checksum_error_count;
    } t_frame_report;

    typedef enum logic [2:0] {
        FR_GOOD,
        FR_BAD_START,
        FR_BAD_SUM,
        FR_BAD_BOTH,
        FR_CUT
    } t_frame_kind;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } t_rx_pattern;

    // DUT connections; every input starts at a known value
    logic                        clk;
    logic                        rst_n       = 1'b0;
    logic                        in_valid    = 1'b0;
    logic                        in_ready;
    logic [7:0]                  rx_byte     = '0;
    logic                        first_byte  = 1'b0;
    logic                        cfg_valid   = 1'b0;
    logic                        cfg_ready;
    logic [7:0]                  start_marker = '0;
    logic                        out_valid;
    logic                        out_ready   = 1'b0;
    logic [1:0]                  status;
    logic [sfc_pkg::ANGLE_W-1:0] angle_tenths;
    logic signed [31:0]          position;
    logic [31:0]                 timestamp;
    logic [31:0]                 frame_count;
    logic [31:0]                 bad_start_count;
    logic [31:0]                 checksum_error_count;

    // Frame model state
    logic [7:0]                  marker_model;
    logic [sfc_pkg::IDX_W-1:0]   byte_pos;
    logic [7:0]                  byte_sum;
    logic [7:0]                  frame_bytes [sfc_pkg::SUM_LEN];
    logic [sfc_pkg::ANGLE_W-1:0] held_angle;
    logic [31:0]                 held_position;
    logic [31:0]                 held_timestamp;
    logic [31:0]                 frames_total;
    logic [31:0]                 bad_start_total;
    logic [31:0]                 sum_error_total;

    t_frame_report         expected_reports [$];
    t_rx_item              pending_bytes [$];

    // Handshake flags, updated at the rising edge
    bit                    in_xfer  = 1'b0;
    bit                    cfg_xfer = 1'b0;
    bit                    out_xfer = 1'b0;
    int                    quiet_cycles = 0;
    int                    mismatch_count = 0;

    // Sender and receiver pacing
    int                    burst_left = 1;
    int                    gap_left = 0;
    int                    hold_left = 0;
    int                    pattern_left = 0;
    t_rx_pattern           rx_pattern = RX_ALWAYS;
    logic                  long_hold_req = 1'b0;
    bit                    long_hold_done = 1'b0;

    // Stimulus side view of the marker and of an unfinished frame
    logic [7:0]            phase_marker = sfc_pkg::MARKER_RESET;
    bit                    frame_open = 1'b0;

    sensor_frame_checker_top dut (
        .i_clk                  (clk),
        .i_rst_n                (rst_n),
        .i_in_valid             (in_valid),
        .o_in_ready             (in_ready),
        .i_rx_byte              (rx_byte),
        .i_first_byte           (first_byte),
        .i_cfg_valid            (cfg_valid),
        .o_cfg_ready            (cfg_ready),
        .i_start_marker         (start_marker),
        .o_out_valid            (out_valid),
        .i_out_ready            (out_ready),
        .o_status               (status),
        .o_angle_tenths         (angle_tenths),
        .o_position             (position),
        .o_timestamp            (timestamp),
        .o_frame_count          (frame_count),
        .o_bad_start_count      (bad_start_count),
        .o_checksum_error_count (checksum_error_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Frame model
    // ------------------------------------------------------------------------
    task automatic clear_model();
        marker_model    = sfc_pkg::MARKER_RESET;
        byte_pos        = '0;
        byte_sum        = '0;
        foreach (frame_bytes[i]) frame_bytes[i] = '0;
        held_angle      = '0;
        held_position   = '0;
        held_timestamp  = '0;
        frames_total    = '0;
        bad_start_total = '0;
        sum_error_total = '0;
    endtask

    // Takes one byte; returns 1 with the report when the byte closes a frame
    function automatic bit take_byte(input logic [7:0] b, input logic first,
                                     output t_frame_report rep);
        logic [31:0] raw;
        rep = '0;
        raw = '0;
        if (first) byte_pos = '0;
        if (byte_pos < sfc_pkg::SUM_LEN) begin
            frame_bytes[byte_pos] = b;
            byte_sum = (byte_pos == 0) ? b : byte_sum + b;
            byte_pos = byte_pos + 1'b1;
            return 1'b0;
        end
        // checksum byte closes the frame
        byte_pos = '0;
        frames_total = frames_total + 1;
        if (frame_bytes[0] != marker_model) begin
            rep.status = sfc_pkg::ST_BAD_START;
            bad_start_total = bad_start_total + 1;
        end else if (byte_sum != b) begin
            rep.status = sfc_pkg::ST_SUM_ERR;
            sum_error_total = sum_error_total + 1;
        end else begin
            rep.status = sfc_pkg::ST_OK;
            raw = {16'h0, frame_bytes[2], frame_bytes[1]};
            held_angle = sfc_pkg::ANGLE_W'((raw * ANGLE_MUL) / ANGLE_DIVISOR);
            held_position = {frame_bytes[6], frame_bytes[5], frame_bytes[4], frame_bytes[3]};
            held_timestamp = {frame_bytes[10], frame_bytes[9], frame_bytes[8], frame_bytes[7]};
        end
        rep.angle                = held_angle;
        rep.position             = held_position;
        rep.timestamp            = held_timestamp;
        rep.frame_count          = frames_total;
        rep.bad_start_count      = bad_start_total;
        rep.checksum_error_count = sum_error_total;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] MISMATCH %s: got 0x%08h, expected 0x%08h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Monitor: tracks transfers, predicts, checks, and guards against hangs
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        t_frame_report rep;
        t_frame_report want;
        in_xfer  = rst_n && in_valid && in_ready;
        cfg_xfer = rst_n && cfg_valid && cfg_ready;
        out_xfer = rst_n && out_valid && out_ready;

        if (!rst_n) clear_model();
        if (cfg_xfer) marker_model = start_marker;

        if (in_xfer) begin
            if (take_byte(rx_byte, first_byte, rep)) expected_reports.push_back(rep);
        end

        if (out_xfer) begin
            if (expected_reports.size() == 0) begin
                report_mismatch("result with none expected", 32'(status), 32'h0);
            end else begin
                want = expected_reports.pop_front();
                check_field("status", 32'(status), 32'(want.status));
                check_field("angle_tenths", 32'(angle_tenths), 32'(want.angle));
                check_field("position", position, want.position);
                check_field("timestamp", timestamp, want.timestamp);
                check_field("frame_count", frame_count, want.frame_count);
                check_field("bad_start_count", bad_start_count, want.bad_start_count);
                check_field("checksum_error_count", checksum_error_count,
                            want.checksum_error_count);
            end
        end

        // watchdog: cycles without any transfer
        if (!rst_n || in_xfer || cfg_xfer || out_xfer) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Byte driver: bursts of random length separated by random gaps
    // ------------------------------------------------------------------------
    always @(negedge clk) begin : byte_driver
        t_rx_item item;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_xfer) begin
            // byte still offered, hold it
        end else if (gap_left > 0) begin
            gap_left--;
            in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
            item = pending_bytes.pop_front();
            rx_byte    <= item.data;
            first_byte <= item.first;
            in_valid   <= 1'b1;
            if (burst_left > 1) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
        end else begin
            in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: changing stall patterns plus one long hold-off
    // ------------------------------------------------------------------------
    always @(negedge clk) begin : result_receiver
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                rx_pattern = t_rx_pattern'($urandom_range(0, 3));
                pattern_left = $urandom_range(20, 120);
            end else begin
                pattern_left--;
            end
            case (rx_pattern)
                RX_ALWAYS: out_ready <= 1'b1;
                RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                default:   out_ready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Random word that often lands on an extreme
    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Queues the first n_bytes bytes of a frame of the given kind
    task automatic push_frame(input t_frame_kind kind, input logic lead_first,
                              input logic [15:0] raw, input logic [31:0] pos,
                              input logic [31:0] stamp, input int n_bytes);
        logic [7:0] fb [FRAME_BYTES];
        logic [7:0] sum;
        t_rx_item   item;
        if (kind == FR_BAD_START || kind == FR_BAD_BOTH)
            fb[0] = phase_marker ^ 8'($urandom_range(1, 255));
        else
            fb[0] = phase_marker;
        {fb[2], fb[1]} = raw;
        {fb[6], fb[5], fb[4], fb[3]} = pos;
        {fb[10], fb[9], fb[8], fb[7]} = stamp;
        sum = '0;
        for (int n = 0; n < sfc_pkg::SUM_LEN; n++) sum = sum + fb[n];
        if (kind == FR_BAD_SUM || kind == FR_BAD_BOTH)
            fb[sfc_pkg::SUM_LEN] = sum + 8'($urandom_range(1, 255));
        else
            fb[sfc_pkg::SUM_LEN] = sum;
        for (int n = 0; n < n_bytes; n++) begin
            item.data  = fb[n];
            item.first = (n == 0) ? lead_first : 1'b0;
            pending_bytes.push_back(item);
        end
        frame_open = (n_bytes < FRAME_BYTES);
    endtask

    // Waits until every byte is taken and every result has come back
    task automatic wait_drained();
        bit quiet;
        do begin
            @(posedge clk);
            quiet = (pending_bytes.size() == 0) && !in_valid;
            @(negedge clk);
        end while (!(quiet && expected_reports.size() == 0));
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Start marker write, issued at a falling edge while idle
    task automatic write_marker(input logic [7:0] value);
        cfg_valid    <= 1'b1;
        start_marker <= value;
        do @(negedge clk); while (!cfg_xfer);
        cfg_valid <= 1'b0;
        phase_marker = value;
    endtask

    // Mostly well-formed frames, some with errors, some cut short
    task automatic random_frames(input int count);
        t_frame_kind kind;
        int          pick;
        logic        lead;
        for (int f = 0; f < count; f++) begin
            pick = $urandom_range(0, 99);
            if (pick < 62)      kind = FR_GOOD;
            else if (pick < 74) kind = FR_BAD_SUM;
            else if (pick < 84) kind = FR_BAD_START;
            else if (pick < 90) kind = FR_BAD_BOTH;
            else                kind = FR_CUT;
            // an unfinished frame must be dropped by a restart flag
            lead = frame_open ? 1'b1 : 1'($urandom_range(0, 1));
            push_frame(kind, lead,
                       16'(random_word() ^ 32'($urandom_range(0, 1) << 15)),
                       random_word(), random_word(),
                       (kind == FR_CUT) ? $urandom_range(1, sfc_pkg::SUM_LEN) : FRAME_BYTES);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : sequencer
        logic [7:0] marker;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: partial frame dropped by a restart, a good frame with
        // extreme angle/position/timestamp, then a frame that follows without
        // the restart flag and carries both a bad marker and a bad checksum
        @(posedge clk);
        push_frame(FR_CUT, 1'b1, 16'h1234, 32'h0, 32'h0, 3);
        push_frame(FR_GOOD, 1'b1, 16'hFFFF, 32'h8000_0000, 32'hFFFF_FFFF, FRAME_BYTES);
        push_frame(FR_BAD_BOTH, 1'b0, 16'h0000, 32'h7FFF_FFFF, 32'h0, FRAME_BYTES);
        wait_drained();

        // Random phases, each under its own start marker
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0:       marker = 8'h00;
                1:       marker = 8'hFF;
                2:       marker = 8'($urandom_range(1, 254));
                default: marker = sfc_pkg::MARKER_RESET;
            endcase
            write_marker(marker);
            @(posedge clk);
            if (p == HOLD_PHASE) long_hold_req <= 1'b1;
            random_frames(FRAMES_PER_PHASE);
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
